// ===== hdl/tfc_pkg.sv =====
// Shared types and constants of the trigger/frame correlator.
package tfc_pkg;

  // Event kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_TRIG  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IN_DATA_W  = 232;  // 29 bytes
  localparam int unsigned OUT_BITS   = 514;
  localparam int unsigned OUT_DATA_W = 520;  // 65 bytes

  // One cached frame start.
  typedef struct packed {
    logic              valid;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] pts;
    logic [TIME_W-1:0] wall;
  } frame_t;

  // Cache control from the event stage.
  typedef struct packed {
    logic wr_en;    // store a frame start into one channel
    logic snap_en;  // copy every channel into the snapshot
  } cache_ctl_t;

endpackage

// ===== hdl/tfc_chan_cache.sv =====
// Per-channel frame cache with a whole-array snapshot taken on trigger.
module tfc_chan_cache
  import tfc_pkg::*;
#(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned CH_W     = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cache_ctl_t      ctl,
  input  logic [CH_W-1:0] wr_idx,
  input  frame_t          wr_data,
  input  logic [CH_W-1:0] rd_idx,
  output frame_t          snap_rd
);

  logic [CHANNELS-1:0] cache_vld_r;
  logic [CHANNELS-1:0] snap_vld_r;
  frame_t              cache_r [CHANNELS];
  frame_t              snap_r  [CHANNELS];

  // Valid bits reset; data stays zero-gated until the entry is valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r <= '0;
      snap_vld_r  <= '0;
    end else begin
      if (ctl.wr_en) begin
        cache_vld_r[wr_idx] <= 1'b1;
      end
      if (ctl.snap_en) begin
        snap_vld_r <= cache_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cache_r[wr_idx] <= wr_data;
    end
    if (ctl.snap_en) begin
      for (int i = 0; i < CHANNELS; i++) begin
        snap_r[i] <= cache_r[i];
      end
    end
  end

  always_comb begin
    snap_rd = '0;
    if (snap_vld_r[rd_idx]) begin
      snap_rd       = snap_r[rd_idx];
      snap_rd.valid = 1'b1;
    end
  end

endmodule

// ===== hdl/trigger_frame_correlator.sv =====
// Top level of the trigger/frame correlator.
//
// Pairs trigger edges with camera frame starts. Each input beat carries an
// event kind on in_tuser: trigger edge, frame start, other frame event or
// flush. A trigger snapshots the per-channel cache of latest frame starts
// and arms one pending slot; a second trigger first reports the old one.
// The first frame start on any in-range channel whose wall time is later
// than the pending trigger time closes the match and produces one result
// beat: the trigger, that channel's snapshot and the new frame. A flush
// reports any pending trigger with no next frame.
//
// Pipeline: an accepted beat is registered in the input register while the
// event logic runs, and any result is registered in the output register,
// which drives out_tvalid; a stall can hold the beat between the two.
// Throughput is one beat per cycle; in_tready stays high while a result
// waits, as long as the event in the input register makes no result itself.
// Stall: with out_tvalid high and out_tready low, an event that must emit
// holds in the input register and in_tready drops; non-emitting events go on.
// Reset (rst_n low, synchronous): caches, snapshot and the pending slot
// clear; both stages are emptied.
module trigger_frame_correlator
  import tfc_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] trigger_time_ns, [71:64] channel, [135:72] frame_pts_us,
  // [199:136] frame_wall_ns, [231:200] frame_seq
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]            in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] trig_time_ns, [64] last_valid, [96:65] last_seq,
  // [160:97] last_pts_us, [224:161] last_wall_ns, [288:225] last_delta_ns,
  // [289] next_valid, [321:290] next_seq, [385:322] next_pts_us,
  // [449:386] next_wall_ns, [513:450] next_delta_ns, [519:514] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------- input register ----------------
  logic              s1_vld_r;
  kind_t             s1_kind_r;
  logic [TIME_W-1:0] s1_trig_r;
  logic [CHAN_W-1:0] s1_chan_r;
  frame_t            s1_frame_r;

  logic s1_go;
  assign in_tready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r        <= kind_t'(in_tuser);
      s1_trig_r        <= in_tdata[63:0];
      s1_chan_r        <= in_tdata[71:64];
      s1_frame_r.valid <= 1'b1;
      s1_frame_r.pts   <= in_tdata[135:72];
      s1_frame_r.wall  <= in_tdata[199:136];
      s1_frame_r.seq   <= in_tdata[231:200];
    end
  end

  // ---------------- event stage ----------------
  logic              pend_r;
  logic [TIME_W-1:0] pend_time_r;

  logic            in_range;
  logic            is_frame;
  logic            frame_hit;
  logic            emit;
  logic [CH_W-1:0] chan_idx;
  logic [CH_W-1:0] rd_idx;
  cache_ctl_t      cache_ctl;
  frame_t          snap;

  assign in_range = {1'b0, s1_chan_r} < (CHAN_W + 1)'(CHANNELS);
  assign chan_idx = s1_chan_r[CH_W-1:0];

  always_comb begin
    is_frame  = 1'b0;
    emit      = 1'b0;
    frame_hit = 1'b0;
    case (s1_kind_r)
      KIND_TRIG: begin
        emit = pend_r;
      end
      KIND_FRAME: begin
        is_frame  = in_range;
        frame_hit = in_range && pend_r && (s1_frame_r.wall > pend_time_r);
        emit      = frame_hit;
      end
      KIND_OTHER: begin
        emit = 1'b0;
      end
      KIND_FLUSH: begin
        emit = pend_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Event may retire unless it emits into a full, stalled output register.
  logic out_vld_r;
  assign s1_go = s1_vld_r && (!emit || !out_vld_r || out_tready);

  // In-range frames read their own channel's snapshot; other events read channel 0.
  assign rd_idx = is_frame ? chan_idx : '0;

  always_comb begin
    cache_ctl.wr_en   = s1_go && is_frame;
    cache_ctl.snap_en = s1_go && (s1_kind_r == KIND_TRIG);
  end

  tfc_chan_cache #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cache_ctl),
    .wr_idx  (chan_idx),
    .wr_data (s1_frame_r),
    .rd_idx  (rd_idx),
    .snap_rd (snap)
  );

  // Pending slot
  logic              pend_nxt;
  logic [TIME_W-1:0] pend_time_nxt;

  always_comb begin
    pend_nxt      = pend_r;
    pend_time_nxt = pend_time_r;
    if (s1_go) begin
      if (s1_kind_r == KIND_TRIG) begin
        pend_nxt      = 1'b1;
        pend_time_nxt = s1_trig_r;
      end else if (frame_hit || (s1_kind_r == KIND_FLUSH)) begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      pend_time_r <= '0;
    end else begin
      pend_r      <= pend_nxt;
      pend_time_r <= pend_time_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [OUT_BITS-1:0] res_nxt;
  logic [OUT_BITS-1:0] res_r;
  logic [TIME_W-1:0]   last_delta;
  logic [TIME_W-1:0]   next_delta;
  frame_t              next_fr;
  logic                out_vld_nxt;

  assign last_delta = snap.valid ? (pend_time_r - snap.wall) : '0;
  assign next_fr    = frame_hit ? s1_frame_r : '0;
  assign next_delta = frame_hit ? (s1_frame_r.wall - pend_time_r) : '0;

  assign res_nxt = {next_delta, next_fr.wall, next_fr.pts, next_fr.seq, next_fr.valid,
                    last_delta, snap.wall, snap.pts, snap.seq, snap.valid, pend_time_r};

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), res_r};

endmodule

// ===== tb/sv/trigger_frame_correlator_test.sv =====
// Self-checking testbench of the trigger/frame correlator: stream driver, monitor and predictor.
module trigger_frame_correlator_test
  import tfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned TOTAL_EVENTS = 1900;
  localparam int unsigned IDLE_PCT = 34;
  // receiver hold-off window and a window where neither side idles, in cycles after reset
  localparam int unsigned HOLD_FROM = 500;
  localparam int unsigned HOLD_TO = 720;
  localparam int unsigned BUSY_FROM = 1200;
  localparam int unsigned BUSY_TO = 1600;
  localparam int unsigned DRAIN_EVERY = 400;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one input beat
  typedef struct {
    kind_t             kind;
    logic [TIME_W-1:0] trig;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] pts;
    logic [TIME_W-1:0] wall;
    logic [SEQ_W-1:0]  seq;
    logic              drain_first;  // wait until no report is outstanding before offering
  } event_t;

  // one result beat, first field in the top bits so it casts from out_tdata
  typedef struct packed {
    logic [5:0]        pad;
    logic [TIME_W-1:0] next_delta;
    logic [TIME_W-1:0] next_wall;
    logic [TIME_W-1:0] next_pts;
    logic [SEQ_W-1:0]  next_seq;
    logic              next_valid;
    logic [TIME_W-1:0] last_delta;
    logic [TIME_W-1:0] last_wall;
    logic [TIME_W-1:0] last_pts;
    logic [SEQ_W-1:0]  last_seq;
    logic              last_valid;
    logic [TIME_W-1:0] trig;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  event_t event_q[$];       // beats still to be offered
  report_t report_q[$];     // predicted reports, oldest first
  int unsigned cyc = 0;     // cycles since reset release, owned by the receiver process
  int unsigned mismatch_count = 0;
  int unsigned gen_count = 0;

  // predictor state
  frame_t frame_cache[CHANNELS];
  frame_t frame_snap[CHANNELS];
  logic armed = 1'b0;
  logic [TIME_W-1:0] armed_time = '0;

  trigger_frame_correlator #(.CHANNELS(CHANNELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Report of the armed trigger against one channel's snapshot; the next
  // frame fields stay zero unless a later frame closed the match.
  function automatic report_t build_report(int unsigned src, logic has_next, frame_t nf);
    report_t rep;
    rep = '0;
    rep.trig = armed_time;
    rep.last_valid = frame_snap[src].valid;
    rep.last_seq = frame_snap[src].seq;
    rep.last_pts = frame_snap[src].pts;
    rep.last_wall = frame_snap[src].wall;
    if (frame_snap[src].valid) begin
      rep.last_delta = armed_time - frame_snap[src].wall;
    end
    if (has_next) begin
      rep.next_valid = 1'b1;
      rep.next_seq = nf.seq;
      rep.next_pts = nf.pts;
      rep.next_wall = nf.wall;
      rep.next_delta = nf.wall - armed_time;
    end
    return rep;
  endfunction

  // Advance the predictor by one accepted beat and queue any report it makes.
  task automatic correlate(input event_t ev);
    frame_t nf;
    nf.valid = 1'b1;
    nf.seq = ev.seq;
    nf.pts = ev.pts;
    nf.wall = ev.wall;
    case (ev.kind)
      KIND_TRIG: begin
        // a trigger still waiting is reported against channel 0, no next frame
        if (armed) begin
          report_q.push_back(build_report(0, 1'b0, nf));
        end
        armed = 1'b1;
        armed_time = ev.trig;
        for (int i = 0; i < CHANNELS; i++) begin
          frame_snap[i] = frame_cache[i];
        end
      end
      KIND_FRAME: begin
        if (ev.chan < CHANNELS) begin
          frame_cache[ev.chan] = nf;
          // only a frame strictly later than the trigger closes the match
          if (armed && ev.wall > armed_time) begin
            report_q.push_back(build_report(32'(ev.chan), 1'b1, nf));
            armed = 1'b0;
          end
        end
      end
      KIND_FLUSH: begin
        if (armed) begin
          report_q.push_back(build_report(0, 1'b0, nf));
          armed = 1'b0;
        end
      end
      default: ;  // other frame events change nothing
    endcase
  endtask

  task automatic add_event(input kind_t kind, input logic [TIME_W-1:0] trig,
                           input logic [CHAN_W-1:0] chan, input logic [TIME_W-1:0] pts,
                           input logic [TIME_W-1:0] wall, input logic [SEQ_W-1:0] seq);
    event_t ev;
    ev.kind = kind;
    ev.trig = trig;
    ev.chan = chan;
    ev.pts = pts;
    ev.wall = wall;
    ev.seq = seq;
    ev.drain_first = (event_q.size() % DRAIN_EVERY == DRAIN_EVERY - 1);
    event_q.push_back(ev);
    gen_count++;
  endtask

  task automatic add_frame(input logic [CHAN_W-1:0] chan, input logic [TIME_W-1:0] wall);
    add_event(KIND_FRAME, rand64(), chan, rand64(), wall, $urandom);
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Driver: offers queued beats, holds a beat until it is taken, idles at random.
  always @(posedge clk) begin : drive_proc
    logic taken;
    logic offer;
    event_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        correlate(event_q.pop_front());
      end
      if (!in_tvalid || taken) begin
        offer = event_q.size() != 0;
        if (offer) begin
          ev = event_q[0];
          // pause point: let every outstanding report come back first
          if (ev.drain_first && report_q.size() != 0) begin
            offer = 1'b0;
          end
          if (!(cyc >= BUSY_FROM && cyc < BUSY_TO) && $urandom_range(99) < IDLE_PCT) begin
            offer = 1'b0;
          end
        end
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= {ev.seq, ev.wall, ev.pts, ev.chan, ev.trig};
          in_tuser <= ev.kind;
        end
      end
    end
  end

  // Receiver ready: random stalls, one long hold-off so the block backs up,
  // and a stretch with no stalls at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= HOLD_FROM && cyc < HOLD_TO) begin
        out_tready <= 1'b0;
      end else if (cyc >= BUSY_FROM && cyc < BUSY_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: every result beat against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    report_t want;
    report_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = report_t'(out_tdata);
      if (report_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
      end else begin
        want = report_q.pop_front();
        check_field("trig_time_ns", want.trig, got.trig);
        check_field("last_valid", TIME_W'(want.last_valid), TIME_W'(got.last_valid));
        check_field("last_seq", TIME_W'(want.last_seq), TIME_W'(got.last_seq));
        check_field("last_pts_us", want.last_pts, got.last_pts);
        check_field("last_wall_ns", want.last_wall, got.last_wall);
        check_field("last_delta_ns", want.last_delta, got.last_delta);
        check_field("next_valid", TIME_W'(want.next_valid), TIME_W'(got.next_valid));
        check_field("next_seq", TIME_W'(want.next_seq), TIME_W'(got.next_seq));
        check_field("next_pts_us", want.next_pts, got.next_pts);
        check_field("next_wall_ns", want.next_wall, got.next_wall);
        check_field("next_delta_ns", want.next_delta, got.next_delta);
        check_field("pad", TIME_W'(want.pad), TIME_W'(got.pad));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stim_proc
    logic [TIME_W-1:0] base;
    int unsigned pick;
    for (int i = 0; i < CHANNELS; i++) begin
      frame_cache[i] = '0;
      frame_snap[i] = '0;
    end

    // Directed: idle flush and other events, empty snapshots, late and
    // not-later frames, out-of-range channels, back-to-back triggers, extremes.
    add_event(KIND_FLUSH, TIME_MAX, 8'hff, TIME_MAX, TIME_MAX, '1);
    add_event(KIND_OTHER, TIME_MAX, 8'd0, TIME_MAX, TIME_MAX, '1);
    add_event(KIND_TRIG, 64'd100, 8'hff, TIME_MAX, TIME_MAX, '1);
    add_frame(8'd0, 64'd50);                          // not later: stays armed
    add_frame(8'd0, 64'd100);                         // equal: stays armed
    add_frame(CHAN_W'(CHANNELS), 64'd200);            // first channel out of range
    add_frame(8'hff, TIME_MAX);
    add_event(KIND_OTHER, '0, 8'd0, '0, 64'd200, '0);
    add_event(KIND_FRAME, '0, CHAN_W'(CHANNELS - 1), TIME_MAX, TIME_MAX, '1);  // empty snapshot
    add_event(KIND_TRIG, TIME_MAX, '0, '0, '0, '0);
    add_event(KIND_TRIG, 64'd0, '0, '0, '0, '0);      // reports the one before
    add_event(KIND_FLUSH, '0, '0, '0, '0, '0);        // reports with no next frame
    add_event(KIND_FLUSH, '0, '0, '0, '0, '0);
    add_event(KIND_FRAME, '0, 8'd3, 64'd7, 64'd10, 32'd5);
    add_event(KIND_TRIG, 64'd20, 8'd3, '0, '0, '0);
    add_frame(8'd3, 64'd20);
    add_event(KIND_FRAME, '0, 8'd3, 64'd8, 64'd21, 32'd6);
    add_event(KIND_TRIG, 64'd0, '0, '0, '0, '0);
    add_frame(8'd0, 64'd0);
    add_event(KIND_FRAME, TIME_MAX, 8'd1, '0, 64'd1, '0);
    add_event(KIND_TRIG, 64'h8000_0000_0000_0000, '0, '0, '0, '0);
    add_event(KIND_FRAME, '0, 8'd5, '0, TIME_MAX, '1);

    // Random: mostly trigger/frame sequences with random content, rest noise.
    gen_count = 0;
    while (gen_count < TOTAL_EVENTS) begin
      if ($urandom_range(99) < 70) begin
        base = rand64();
        repeat ($urandom_range(3)) begin
          add_frame(CHAN_W'($urandom_range(CHANNELS - 1)), base - $urandom_range(1, 5000));
        end
        add_event(KIND_TRIG, base, CHAN_W'($urandom), rand64(), rand64(), $urandom);
        if ($urandom_range(99) < 15) begin
          add_frame(CHAN_W'($urandom_range(CHANNELS - 1)), base - $urandom_range(0, 1000));
        end
        if ($urandom_range(99) < 10) begin
          add_event(KIND_OTHER, rand64(), CHAN_W'($urandom), rand64(), base + 1, $urandom);
          add_frame(CHAN_W'($urandom_range(CHANNELS, 255)), base + $urandom_range(1, 1000));
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
          add_frame(CHAN_W'($urandom_range(CHANNELS - 1)), base + $urandom_range(1, 100000));
        end else if (pick < 88) begin
          add_event(KIND_FLUSH, rand64(), CHAN_W'($urandom), rand64(), rand64(), $urandom);
        end else if (pick < 95) begin
          add_event(KIND_TRIG, base + $urandom_range(0, 1000), CHAN_W'($urandom), rand64(),
                    rand64(), $urandom);
        end
      end else begin
        add_event(kind_t'($urandom_range(3)), rand64(),
                  CHAN_W'(($urandom_range(1)) ? $urandom_range(255)
                                              : $urandom_range(CHANNELS - 1)),
                  rand64(), rand64(), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (event_q.size() != 0 || report_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tfc_pkg.sv
hdl/tfc_chan_cache.sv
hdl/trigger_frame_correlator.sv
tb/sv/trigger_frame_correlator_test.sv
